// ===== rtl/spc_pkg.sv =====
// Package for the stereo parallel compressor: widths, fixed-point constants,
// register map, control/status structs and the log2 / exp2 lookup tables.
// No dependencies.
package spc_pkg;

   // ---------------- sizes ----------------
   localparam int SAMPLE_BITS     = 24;
   localparam int TABLE_ADDR_BITS = 8;
   localparam int TBL_N           = (1 << TABLE_ADDR_BITS) + 1;

   localparam int SH_W    = $clog2(SAMPLE_BITS);   // normalize shift count
   localparam int LOG_FB  = 31 - TABLE_ADDR_BITS;  // log interp fraction bits
   localparam int EXP_FB  = 16 - TABLE_ADDR_BITS;  // exp interp fraction bits
   localparam int LVL_W   = 26;                    // dB level, Q10.16
   localparam int ENV_W   = 26;
   localparam int DIFF_W  = 27;
   localparam int OVER_W  = 27;
   localparam int NET_W   = 28;
   localparam int OCT_W   = 27;                    // octaves, Q16
   localparam int IP_W    = OCT_W - 16;
   localparam int T_W     = SAMPLE_BITS + 2;
   localparam int U_W     = SAMPLE_BITS + 20;
   localparam int WET_W   = 62;
   localparam int Y_W     = 48;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // ---------------- constants ----------------
   localparam logic signed [LVL_W-1:0] DB_FLOOR  = -26'sd13107200;  // -200 dB
   localparam logic signed [ENV_W-1:0] ENV_RESET = -26'sd6553600;   // -100 dB
   localparam logic [18:0] DB_PER_OCT = 19'd394566;   // 20*log10(2), Q16
   localparam logic [21:0] OCT_PER_DB = 22'd2786635;  // 1/(20*log10(2)), Q24
   localparam logic signed [WET_W-1:0] WET_CLAMP = WET_W'(64'd1 << 60);
   localparam logic signed [Y_W-1:0] Y_HI =
      Y_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [Y_W-1:0] Y_LO = -Y_HI - Y_W'(1);

   // ---------------- register map ----------------
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 3'd0,
      CSR_SLOPE     = 3'd1,
      CSR_DRY       = 3'd2,
      CSR_WET       = 3'd3,
      CSR_MAKEUP    = 3'd4,
      CSR_ATTACK    = 3'd5,
      CSR_RELEASE   = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] threshold;   // Q8.8 dB
      logic [15:0]        slope;       // Q0.16
      logic [15:0]        dry_level;   // Q1.15
      logic [16:0]        wet_level;   // Q2.15
      logic signed [15:0] makeup;      // Q8.8 dB
      logic [23:0]        attack_factor;
      logic [23:0]        release_factor;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      threshold:      -16'sd6144,
      slope:          16'd57344,
      dry_level:      16'd22938,
      wet_level:      17'd16384,
      makeup:         16'sd1536,
      attack_factor:  24'd16603359,
      release_factor: 24'd16773721
   };

   // ---------------- controller <-> datapath ----------------
   typedef struct packed {
      logic cap;       // capture input word
      logic norm;      // one normalize step
      logic log;       // log2 interpolation
      logic lvl;       // octaves -> dB
      logic env;       // envelope update
      logic gain;      // gain reduction
      logic oct;       // dB -> octaves
      logic mant;      // exp2 interpolation
      logic mul;       // x * mantissa
      logic wetm;      // * wet level
      logic scale;     // * 2^intpart
      logic sum;       // dry + wet
      logic load_out;  // saturate into output register
   } cmd_type;

   typedef struct packed {
      logic norm_done;
   } status_type;

   // ---------------- tables ----------------
   typedef logic [16:0] log_tab_type [0:TBL_N-1];
   typedef logic [31:0] exp_tab_type [0:TBL_N-1];

   // log2(1 + i/2^A) in Q16, bit by bit through repeated squaring
   function automatic log_tab_type build_log_tab();
      log_tab_type tab;
      logic [63:0] z;
      logic [31:0] r;
      for (int i = 0; i < (1 << TABLE_ADDR_BITS); i++) begin
         z = 64'((1 << TABLE_ADDR_BITS) + i) << (30 - TABLE_ADDR_BITS);
         r = '0;
         for (int k = 0; k < 20; k++) begin
            z = (z * z) >> 30;
            r = r << 1;
            if (z >= (64'd1 << 31)) begin
               r[0] = 1'b1;
               z = z >> 1;
            end
         end
         tab[i] = 17'((r + 32'd8) >> 4);
      end
      tab[1 << TABLE_ADDR_BITS] = 17'd65536;
      return tab;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bq;
      v   = v_in;
      res = '0;
      bq  = 64'd1 << 62;
      while (bq > v) bq = bq >> 2;
      while (bq != 64'd0) begin
         if (v >= res + bq) begin
            v   = v - (res + bq);
            res = (res >> 1) + bq;
         end else begin
            res = res >> 1;
         end
         bq = bq >> 2;
      end
      return res;
   endfunction

   // 2^(i/2^A) in Q30, product of repeated square roots of two
   function automatic exp_tab_type build_exp_tab();
      exp_tab_type tab;
      logic [63:0] root [0:TABLE_ADDR_BITS];
      logic [63:0] p;
      root[0] = 64'd1 << 31;
      for (int k = 1; k <= TABLE_ADDR_BITS; k++)
         root[k] = isqrt64(root[k-1] << 30);
      for (int i = 0; i < (1 << TABLE_ADDR_BITS); i++) begin
         p = 64'd1 << 30;
         for (int k = 0; k < TABLE_ADDR_BITS; k++)
            if (((i >> k) & 1) != 0)
               p = (p * root[TABLE_ADDR_BITS-k] + (64'd1 << 29)) >> 30;
         tab[i] = 32'(p);
      end
      tab[1 << TABLE_ADDR_BITS] = 32'd1 << 31;
      return tab;
   endfunction

   localparam log_tab_type LOG_TAB = build_log_tab();
   localparam exp_tab_type EXP_TAB = build_exp_tab();

endpackage

// ===== rtl/spc_csr.sv =====
// Configuration register file of the stereo parallel compressor.
// Depends on spc_pkg (register map, reset values).
module spc_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [spc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [spc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output spc_pkg::cfg_type                cfg
);

   spc_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            spc_pkg::CSR_THRESHOLD: cfg_in.threshold      = $signed(csr_wdata[15:0]);
            spc_pkg::CSR_SLOPE:     cfg_in.slope          = csr_wdata[15:0];
            spc_pkg::CSR_DRY:       cfg_in.dry_level      = csr_wdata[15:0];
            spc_pkg::CSR_WET:       cfg_in.wet_level      = csr_wdata[16:0];
            spc_pkg::CSR_MAKEUP:    cfg_in.makeup         = $signed(csr_wdata[15:0]);
            spc_pkg::CSR_ATTACK:    cfg_in.attack_factor  = csr_wdata[23:0];
            spc_pkg::CSR_RELEASE:   cfg_in.release_factor = csr_wdata[23:0];
            default: ;  // unmapped index, dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= spc_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/spc_ctrl.sv =====
// Sequencer of the stereo parallel compressor: steps one word through the
// datapath and owns both handshakes. Depends on spc_pkg (cmd/status structs).
module spc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output spc_pkg::cmd_type     cmd,
   input  spc_pkg::status_type  status
);

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_NORM  = 13'b0000000000010,
      ST_LOG   = 13'b0000000000100,
      ST_LVL   = 13'b0000000001000,
      ST_ENV   = 13'b0000000010000,
      ST_GAIN  = 13'b0000000100000,
      ST_OCT   = 13'b0000001000000,
      ST_MANT  = 13'b0000010000000,
      ST_MUL   = 13'b0000100000000,
      ST_WETM  = 13'b0001000000000,
      ST_SCALE = 13'b0010000000000,
      ST_SUM   = 13'b0100000000000,
      ST_OUT   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.cap  = 1'b1;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (status.norm_done) state_in = ST_LOG;
            else cmd.norm = 1'b1;
         end
         ST_LOG:   begin cmd.log   = 1'b1; state_in = ST_LVL;   end
         ST_LVL:   begin cmd.lvl   = 1'b1; state_in = ST_ENV;   end
         ST_ENV:   begin cmd.env   = 1'b1; state_in = ST_GAIN;  end
         ST_GAIN:  begin cmd.gain  = 1'b1; state_in = ST_OCT;   end
         ST_OCT:   begin cmd.oct   = 1'b1; state_in = ST_MANT;  end
         ST_MANT:  begin cmd.mant  = 1'b1; state_in = ST_MUL;   end
         ST_MUL:   begin cmd.mul   = 1'b1; state_in = ST_WETM;  end
         ST_WETM:  begin cmd.wetm  = 1'b1; state_in = ST_SCALE; end
         ST_SCALE: begin cmd.scale = 1'b1; state_in = ST_SUM;   end
         ST_SUM:   begin cmd.sum   = 1'b1; state_in = ST_OUT;   end
         ST_OUT: begin
            // hold until the previous result word has left
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (cmd.load_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/spc_dp.sv =====
// Datapath of the stereo parallel compressor: detector, dB envelope, gain
// computer and two blend lanes. Depends on spc_pkg (widths, tables, structs).
module spc_dp (
   input  logic                                    clock,
   input  logic                                    reset,
   input  spc_pkg::cmd_type                        cmd,
   output spc_pkg::status_type                     status,
   input  spc_pkg::cfg_type                        cfg,
   input  logic signed [spc_pkg::SAMPLE_BITS-1:0]  req_left_in,
   input  logic signed [spc_pkg::SAMPLE_BITS-1:0]  req_right_in,
   input  logic                                    req_block_end_in,
   output logic signed [spc_pkg::SAMPLE_BITS-1:0]  rsp_left_out,
   output logic signed [spc_pkg::SAMPLE_BITS-1:0]  rsp_right_out,
   output logic                                    rsp_block_end_out,
   output logic                                    rsp_clipped
);

   localparam int S      = spc_pkg::SAMPLE_BITS;
   localparam int A      = spc_pkg::TABLE_ADDR_BITS;
   localparam int SH_W   = spc_pkg::SH_W;
   localparam int LOG_FB = spc_pkg::LOG_FB;
   localparam int EXP_FB = spc_pkg::EXP_FB;
   localparam int LVL_W  = spc_pkg::LVL_W;
   localparam int ENV_W  = spc_pkg::ENV_W;
   localparam int DIFF_W = spc_pkg::DIFF_W;
   localparam int OVER_W = spc_pkg::OVER_W;
   localparam int NET_W  = spc_pkg::NET_W;
   localparam int OCT_W  = spc_pkg::OCT_W;
   localparam int IP_W   = spc_pkg::IP_W;
   localparam int T_W    = spc_pkg::T_W;
   localparam int U_W    = spc_pkg::U_W;
   localparam int WET_W  = spc_pkg::WET_W;
   localparam int Y_W    = spc_pkg::Y_W;
   localparam int LP_W   = SH_W + 35;
   localparam int MP_W   = S + 33;
   localparam int DP_W   = S + 17;

   localparam logic [16+LOG_FB:0]      LOG_RND = (17+LOG_FB)'(1) << (LOG_FB - 1);
   localparam logic [LP_W-1:0]         LVL_RND = LP_W'(32768);
   localparam logic signed [52:0]      ENV_RND = 53'sd8388608;
   localparam logic signed [43:0]      GR_RND  = 44'sd32768;
   localparam logic signed [50:0]      OCT_RND = 51'sd8388608;
   localparam logic [31+EXP_FB:0]      EXP_RND = (32+EXP_FB)'(1) << (EXP_FB - 1);
   localparam logic signed [MP_W-1:0]  MP_RND  = MP_W'(1) <<< 29;
   localparam logic signed [62:0]      Y_RND   = 63'sd16384;

   // ---------------- registers ----------------
   logic signed [S-1:0]      x_ff [2], x_in [2];
   logic                     bend_ff, bend_in;
   logic [S-1:0]             nm_ff, nm_in;
   logic [SH_W-1:0]          sh_ff, sh_in;
   logic                     zero_ff, zero_in;
   logic [16:0]              f_ff, f_in;
   logic signed [LVL_W-1:0]  lvl_ff, lvl_in;
   logic signed [ENV_W-1:0]  env_ff, env_in;
   logic signed [OVER_W-1:0] gr_ff, gr_in;
   logic signed [OCT_W-1:0]  oct_ff, oct_in;
   logic [31:0]              mant_ff, mant_in;
   logic signed [T_W-1:0]    t_ff [2], t_in [2];
   logic signed [U_W-1:0]    u_ff [2], u_in [2];
   logic signed [WET_W-1:0]  wet_ff [2], wet_in [2];
   logic signed [Y_W-1:0]    y_ff [2], y_in [2];
   logic signed [S-1:0]      out_ff [2], out_in [2];
   logic                     obend_ff, obend_in, clip_ff, clip_in;

   // ---------------- detector ----------------
   logic [S-1:0] abs_l, abs_r, mag;
   assign abs_l = req_left_in[S-1]  ? S'(-req_left_in)  : S'(req_left_in);
   assign abs_r = req_right_in[S-1] ? S'(-req_right_in) : S'(req_right_in);
   assign mag   = (abs_l > abs_r) ? abs_l : abs_r;

   assign status.norm_done = nm_ff[S-1] | zero_ff;

   // log2 mantissa interpolation
   logic [30:0]          frac;
   logic [A:0]           lidx_a, lidx_b;
   logic [16:0]          l0, l1, ldiff;
   logic [16+LOG_FB:0]   lprod;
   logic [16:0]          f_calc;
   assign frac   = 31'(nm_ff[S-2:0]) << (32 - S);
   assign lidx_a = (A+1)'(frac[30 -: A]);
   assign lidx_b = lidx_a + (A+1)'(1);
   assign l0     = spc_pkg::LOG_TAB[lidx_a];
   assign l1     = spc_pkg::LOG_TAB[lidx_b];
   assign ldiff  = l1 - l0;
   assign lprod  = ldiff * frac[LOG_FB-1:0];
   assign f_calc = l0 + 17'((lprod + LOG_RND) >> LOG_FB);

   // octaves below full scale -> dB
   logic signed [SH_W+17:0] neg;
   logic [SH_W+15:0]        negc;
   logic [LP_W-1:0]         lprod2;
   logic [18:0]             DB_PER_OCT_EXT;
   logic signed [LVL_W-1:0] lvl_calc;
   assign neg      = $signed({2'b00, sh_ff, 16'h0000}) - $signed({(SH_W+1)'(0), f_ff});
   assign negc     = neg[SH_W+17] ? '0 : neg[SH_W+15:0];
   assign DB_PER_OCT_EXT = spc_pkg::DB_PER_OCT;
   assign lprod2   = negc * DB_PER_OCT_EXT;
   assign lvl_calc = zero_ff ? spc_pkg::DB_FLOOR
                             : -$signed(LVL_W'((lprod2 + LVL_RND) >> 16));

   // ---------------- envelope ----------------
   logic [23:0]              coef_sel;
   logic [24:0]              coef;
   logic signed [DIFF_W-1:0] ediff;
   logic signed [52:0]       eprod, esum;
   logic signed [ENV_W-1:0]  env_calc;
   assign coef_sel = (lvl_ff > env_ff) ? cfg.attack_factor : cfg.release_factor;
   assign coef     = 25'h1000000 - {1'b0, coef_sel};
   assign ediff    = DIFF_W'(lvl_ff) - DIFF_W'(env_ff);
   assign eprod    = $signed({1'b0, coef}) * ediff;
   assign esum     = eprod + ENV_RND;
   assign env_calc = env_ff + esum[24 +: ENV_W];

   // ---------------- gain computer ----------------
   logic signed [OVER_W-1:0] over;
   logic signed [43:0]       gprod, gsum;
   logic signed [OVER_W-1:0] gr_calc;
   assign over    = OVER_W'(env_ff) - OVER_W'($signed({cfg.threshold, 8'h00}));
   assign gprod   = $signed({1'b0, cfg.slope}) * over;
   assign gsum    = gprod + GR_RND;
   assign gr_calc = (over > 0) ? gsum[16 +: OVER_W] : '0;

   logic signed [NET_W-1:0] net;
   logic signed [50:0]      oprod, osum;
   assign net   = NET_W'($signed({cfg.makeup, 8'h00})) - NET_W'(gr_ff);
   assign oprod = net * $signed({1'b0, spc_pkg::OCT_PER_DB});
   assign osum  = oprod + OCT_RND;

   // exp2 of the fractional octave
   logic signed [IP_W-1:0] ip;
   logic [A:0]             eidx_a, eidx_b;
   logic [31:0]            e0, e1, exdiff, mant_calc;
   logic [31+EXP_FB:0]     xprod;
   assign ip        = oct_ff[OCT_W-1:16];
   assign eidx_a    = (A+1)'(oct_ff[15 -: A]);
   assign eidx_b    = eidx_a + (A+1)'(1);
   assign e0        = spc_pkg::EXP_TAB[eidx_a];
   assign e1        = spc_pkg::EXP_TAB[eidx_b];
   assign exdiff    = e1 - e0;
   assign xprod     = exdiff * oct_ff[EXP_FB-1:0];
   assign mant_calc = e0 + 32'((xprod + EXP_RND) >> EXP_FB);

   // ---------------- blend lanes ----------------
   logic [IP_W-1:0]          sneg;
   logic [5:0]               s6, ip6;
   logic [60:0]              lim;
   logic [65:0]              rnd;
   logic signed [MP_W-1:0]   mprod [2], msum [2];
   logic signed [U_W-1:0]    wprod [2];
   logic [U_W-1:0]           umag [2];
   logic signed [65:0]       ext [2];
   logic signed [WET_W-1:0]  wet_calc [2];
   logic signed [DP_W-1:0]   dprod [2];
   logic signed [62:0]       ysum [2];

   assign sneg = IP_W'(-ip);
   assign s6   = sneg[5:0];
   assign ip6  = ip[5:0];
   assign lim  = 61'(1) << (6'd60 - ip6);
   assign rnd  = 66'(1) << (s6 - 6'd1);

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         mprod[i] = x_ff[i] * $signed({1'b0, mant_ff});
         msum[i]  = mprod[i] + MP_RND;
         wprod[i] = t_ff[i] * $signed({1'b0, cfg.wet_level});
         umag[i]  = u_ff[i][U_W-1] ? U_W'(-u_ff[i]) : U_W'(u_ff[i]);
         ext[i]   = 66'(u_ff[i]) + $signed(rnd);
         if (!ip[IP_W-1]) begin
            if (ip > $signed(IP_W'(40)) || 61'(umag[i]) > lim) begin
               if (u_ff[i] < 0)       wet_calc[i] = -spc_pkg::WET_CLAMP;
               else if (u_ff[i] > 0)  wet_calc[i] = spc_pkg::WET_CLAMP;
               else                   wet_calc[i] = '0;
            end else begin
               wet_calc[i] = WET_W'(u_ff[i]) <<< ip6;
            end
         end else if (sneg > IP_W'(62)) begin
            wet_calc[i] = '0;
         end else begin
            wet_calc[i] = WET_W'(ext[i] >>> s6);
         end
         dprod[i] = x_ff[i] * $signed({1'b0, cfg.dry_level});
         ysum[i]  = 63'(dprod[i]) + 63'(wet_ff[i]) + Y_RND;
      end
   end

   // ---------------- next state ----------------
   always_comb begin
      x_in     = x_ff;
      bend_in  = bend_ff;
      nm_in    = nm_ff;
      sh_in    = sh_ff;
      zero_in  = zero_ff;
      f_in     = f_ff;
      lvl_in   = lvl_ff;
      env_in   = env_ff;
      gr_in    = gr_ff;
      oct_in   = oct_ff;
      mant_in  = mant_ff;
      t_in     = t_ff;
      u_in     = u_ff;
      wet_in   = wet_ff;
      y_in     = y_ff;
      out_in   = out_ff;
      obend_in = obend_ff;
      clip_in  = clip_ff;

      if (cmd.cap) begin
         x_in[0] = req_left_in;
         x_in[1] = req_right_in;
         bend_in = req_block_end_in;
         nm_in   = mag;
         sh_in   = '0;
         zero_in = (mag == '0);
      end
      if (cmd.norm && !status.norm_done) begin
         // coarse step of four while the top nibble is clear
         if (nm_ff[S-1 -: 4] == 4'h0) begin
            nm_in = nm_ff << 4;
            sh_in = sh_ff + SH_W'(4);
         end else begin
            nm_in = nm_ff << 1;
            sh_in = sh_ff + SH_W'(1);
         end
      end
      if (cmd.log)  f_in    = f_calc;
      if (cmd.lvl)  lvl_in  = lvl_calc;
      if (cmd.env)  env_in  = env_calc;
      if (cmd.gain) gr_in   = gr_calc;
      if (cmd.oct)  oct_in  = osum[24 +: OCT_W];
      if (cmd.mant) mant_in = mant_calc;
      for (int i = 0; i < 2; i++) begin
         if (cmd.mul)   t_in[i]   = msum[i][30 +: T_W];
         if (cmd.wetm)  u_in[i]   = wprod[i];
         if (cmd.scale) wet_in[i] = wet_calc[i];
         if (cmd.sum)   y_in[i]   = Y_W'(ysum[i] >>> 15);
      end
      if (cmd.load_out) begin
         clip_in  = 1'b0;
         obend_in = bend_ff;
         for (int i = 0; i < 2; i++) begin
            if (y_ff[i] > spc_pkg::Y_HI) begin
               out_in[i] = S'(spc_pkg::Y_HI);
               clip_in   = 1'b1;
            end else if (y_ff[i] < spc_pkg::Y_LO) begin
               out_in[i] = S'(spc_pkg::Y_LO);
               clip_in   = 1'b1;
            end else begin
               out_in[i] = S'(y_ff[i]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff <= spc_pkg::ENV_RESET;
      end else begin
         env_ff <= env_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      bend_ff  <= bend_in;
      nm_ff    <= nm_in;
      sh_ff    <= sh_in;
      zero_ff  <= zero_in;
      f_ff     <= f_in;
      lvl_ff   <= lvl_in;
      gr_ff    <= gr_in;
      oct_ff   <= oct_in;
      mant_ff  <= mant_in;
      t_ff     <= t_in;
      u_ff     <= u_in;
      wet_ff   <= wet_in;
      y_ff     <= y_in;
      out_ff   <= out_in;
      obend_ff <= obend_in;
      clip_ff  <= clip_in;
   end

   assign rsp_left_out      = out_ff[0];
   assign rsp_right_out     = out_ff[1];
   assign rsp_block_end_out = obend_ff;
   assign rsp_clipped       = clip_ff;

endmodule

// ===== rtl/stereo_parallel_compressor_core.sv =====
// The single sequencer and its shared datapath handle one stereo word at a
//   time; the normalize loop of the log detector runs until the magnitude's
//   top bit is set or the magnitude is zero (24-bit samples).
// Reset (synchronous, active high): configuration registers to defaults,
//   envelope to -100 dB, no result pending.
//
// Stereo parallel ("New York") compressor top level. Depends on spc_pkg and
// instantiates spc_csr, spc_ctrl and spc_dp.
//
// Flow per word:
//   capture -> peak magnitude -> normalize (shift by 4 or 1 per cycle)
//   -> log2 by table + interpolation -> dB (Q10.16)
//   -> one-pole envelope in dB (attack when rising, release otherwise)
//   -> gain reduction = slope * (env - threshold) above threshold
//   -> net dB = makeup - reduction -> octaves -> exp2 by table
//   -> per channel: dry*dry_level + x*gain*wet_level, rounded, saturated.
// The result sits in an output register; a new word is taken while it
// waits, and the sequencer only stalls at its final step if the previous
// result has not been taken yet.
module stereo_parallel_compressor_core (
   input  logic                                    clock,
   input  logic                                    reset,
   // input words
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [spc_pkg::SAMPLE_BITS-1:0]  req_left_in,
   input  logic signed [spc_pkg::SAMPLE_BITS-1:0]  req_right_in,
   input  logic                                    req_block_end_in,
   // result words
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [spc_pkg::SAMPLE_BITS-1:0]  rsp_left_out,
   output logic signed [spc_pkg::SAMPLE_BITS-1:0]  rsp_right_out,
   output logic                                    rsp_block_end_out,
   output logic                                    rsp_clipped,
   // register writes (index 7 is ignored)
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [spc_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [spc_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   spc_pkg::cfg_type    cfg;
   spc_pkg::cmd_type    cmd;
   spc_pkg::status_type status;

   // user's rule, unenforced: registers are only rewritten while idle, so no shadowing is needed
   spc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   spc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   spc_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .cfg               (cfg),
      .req_left_in       (req_left_in),
      .req_right_in      (req_right_in),
      .req_block_end_in  (req_block_end_in),
      .rsp_left_out      (rsp_left_out),
      .rsp_right_out     (rsp_right_out),
      .rsp_block_end_out (rsp_block_end_out),
      .rsp_clipped       (rsp_clipped)
   );

endmodule

// ===== rtl/spc_checker.sv =====
// Port-level checks for the stereo parallel compressor, bound to the top.
// Depends on spc_pkg (sample width).
module spc_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_ready,
   input logic signed [spc_pkg::SAMPLE_BITS-1:0]  req_left_in,
   input logic signed [spc_pkg::SAMPLE_BITS-1:0]  req_right_in,
   input logic                                    req_block_end_in,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic signed [spc_pkg::SAMPLE_BITS-1:0]  rsp_left_out,
   input logic signed [spc_pkg::SAMPLE_BITS-1:0]  rsp_right_out,
   input logic                                    rsp_block_end_out,
   input logic                                    rsp_clipped,
   input logic                                    csr_valid,
   input logic                                    csr_ready,
   input logic [spc_pkg::CSR_IDX_W-1:0]           csr_index,
   input logic [spc_pkg::CSR_DATA_W-1:0]          csr_wdata
);

   localparam int S = spc_pkg::SAMPLE_BITS;
   localparam logic signed [S-1:0] MAX_S = S'(spc_pkg::Y_HI);
   localparam logic signed [S-1:0] MIN_S = S'(spc_pkg::Y_LO);

   // nothing is pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word pending after reset");

   // one word in flight: accepting a word drops ready
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input accepted while busy");

   // a clip flag comes only with a channel at a rail
   a_clip_at_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         rsp_left_out == MAX_S || rsp_left_out == MIN_S ||
         rsp_right_out == MAX_S || rsp_right_out == MIN_S)
      else $error("clipped set without a saturated channel");

   // stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_left_out) && $stable(rsp_right_out) &&
         $stable(rsp_clipped) && $stable(rsp_block_end_out))
      else $error("result word changed while stalled");

endmodule

bind stereo_parallel_compressor_core spc_checker u_spc_checker (.*);

// ===== bench/spc_gain_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the stereo compressor: tracks register writes, predicts
// each result word from its own gain model and compares. Depends on spc_pkg.
module spc_gain_checker (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   input  logic                                    req_ready,
   input  logic signed [spc_pkg::SAMPLE_BITS-1:0]  req_left_in,
   input  logic signed [spc_pkg::SAMPLE_BITS-1:0]  req_right_in,
   input  logic                                    req_block_end_in,
   input  logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   input  logic signed [spc_pkg::SAMPLE_BITS-1:0]  rsp_left_out,
   input  logic signed [spc_pkg::SAMPLE_BITS-1:0]  rsp_right_out,
   input  logic                                    rsp_block_end_out,
   input  logic                                    rsp_clipped,
   input  logic                                    csr_valid,
   input  logic                                    csr_ready,
   input  logic [spc_pkg::CSR_IDX_W-1:0]           csr_index,
   input  logic [spc_pkg::CSR_DATA_W-1:0]          csr_wdata,
   output int                                      fail_count,
   output int                                      words_pending
);

   localparam longint SAT_HI = (64'sd1 <<< (spc_pkg::SAMPLE_BITS - 1)) - 1;
   localparam longint SAT_LO = -(64'sd1 <<< (spc_pkg::SAMPLE_BITS - 1));

   typedef struct {
      logic [spc_pkg::SAMPLE_BITS-1:0] left;
      logic [spc_pkg::SAMPLE_BITS-1:0] right;
      logic                            block_end;
      logic                            clipped;
   } stereo_word_type;

   longint           log2_frac [0:spc_pkg::TBL_N-1];
   longint           pow2_mant [0:spc_pkg::TBL_N-1];
   spc_pkg::cfg_type regs;
   longint           env_db;
   stereo_word_type  pending_words [$];

   function automatic longint round_shift(longint v, int s);
      if (s == 0) return v;
      if (s > 62) return 0;
      return (v + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] acc;
      logic [63:0] res;
      logic [63:0] b;
      acc = v;
      res = 0;
      b = 64'd1 << 62;
      while (b > acc) b = b >> 2;
      while (b != 0) begin
         if (acc >= res + b) begin
            acc = acc - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   initial begin
      logic [63:0] z;
      logic [63:0] p;
      logic [63:0] roots [0:spc_pkg::TABLE_ADDR_BITS];
      longint r;
      // log2(1+i/2^A) bit by bit through squaring
      for (int i = 0; i < (1 << spc_pkg::TABLE_ADDR_BITS); i++) begin
         z = 64'((1 << spc_pkg::TABLE_ADDR_BITS) + i) << (30 - spc_pkg::TABLE_ADDR_BITS);
         r = 0;
         for (int k = 0; k < 20; k++) begin
            z = (z * z) >> 30;
            r = r << 1;
            if (z >= (64'd1 << 31)) begin
               r = r | 1;
               z = z >> 1;
            end
         end
         log2_frac[i] = (r + 8) >> 4;
      end
      log2_frac[1 << spc_pkg::TABLE_ADDR_BITS] = 65536;
      // 2^(i/2^A) from repeated square roots of two, Q30
      roots[0] = 64'd1 << 31;
      for (int k = 1; k <= spc_pkg::TABLE_ADDR_BITS; k++)
         roots[k] = int_sqrt(roots[k-1] << 30);
      for (int i = 0; i < (1 << spc_pkg::TABLE_ADDR_BITS); i++) begin
         p = 64'd1 << 30;
         for (int k = 0; k < spc_pkg::TABLE_ADDR_BITS; k++)
            if ((i >> k) & 1)
               p = (p * roots[spc_pkg::TABLE_ADDR_BITS-k] + (64'd1 << 29)) >> 30;
         pow2_mant[i] = longint'(p);
      end
      pow2_mant[1 << spc_pkg::TABLE_ADDR_BITS] = 64'sd1 <<< 31;
   end

   // peak magnitude -> dB, Q16
   function automatic longint peak_db(longint m);
      int e;
      longint frac, idx, rem, f, neg;
      if (m == 0) return -64'sd13107200;
      e = 0;
      while (e < 31 && (m >> (e + 1)) != 0) e++;
      frac = (m << (31 - e)) & 64'h7FFF_FFFF;
      idx = frac >> spc_pkg::LOG_FB;
      rem = frac & ((64'sd1 <<< spc_pkg::LOG_FB) - 1);
      f = log2_frac[idx] + (((log2_frac[idx+1] - log2_frac[idx]) * rem
                             + (64'sd1 <<< (spc_pkg::LOG_FB - 1))) >>> spc_pkg::LOG_FB);
      neg = longint'(spc_pkg::SAMPLE_BITS - 1 - e) * 65536 - f;
      if (neg < 0) neg = 0;
      return -((neg * 394566 + 32768) >>> 16);
   endfunction

   // unsaturated blend: dry*dry_level + x*gain*wet_level, to integer
   function automatic longint blend_raw(longint x, longint mant, longint ip);
      longint t, u, mag, wet, clampv;
      clampv = 64'sd1 <<< 60;
      t = round_shift(x * mant, 30);
      u = t * longint'(regs.wet_level);
      if (ip >= 0) begin
         mag = u < 0 ? -u : u;
         if (ip > 40 || mag > (clampv >>> ip))
            wet = u < 0 ? -clampv : (u > 0 ? clampv : 0);
         else
            wet = u <<< ip;
      end else begin
         wet = round_shift(u, ip < -63 ? 63 : int'(-ip));
      end
      return round_shift(x * longint'(regs.dry_level) + wet, 15);
   endfunction

   function automatic stereo_word_type compress_pair(longint xl, longint xr, logic be);
      stereo_word_type w;
      longint ml, mr, lvl, c, over, gr, net, oct, ip, fr, idx, rem, mant, yl, yr;
      ml = xl < 0 ? -xl : xl;
      mr = xr < 0 ? -xr : xr;
      lvl = peak_db(ml > mr ? ml : mr);
      // release also when level equals envelope
      c = lvl > env_db ? longint'(regs.attack_factor) : longint'(regs.release_factor);
      env_db = env_db + round_shift(((64'sd1 <<< 24) - c) * (lvl - env_db), 24);
      env_db = longint'(int'(env_db));
      over = env_db - longint'(regs.threshold) * 256;
      gr = over > 0 ? round_shift(longint'(regs.slope) * over, 16) : 0;
      net = longint'(regs.makeup) * 256 - gr;
      oct = round_shift(net * 2786635, 24);
      ip = oct >>> 16;
      fr = oct - ip * 65536;
      idx = fr >> spc_pkg::EXP_FB;
      rem = fr & ((64'sd1 <<< spc_pkg::EXP_FB) - 1);
      mant = pow2_mant[idx] + (((pow2_mant[idx+1] - pow2_mant[idx]) * rem
                                + (64'sd1 <<< (spc_pkg::EXP_FB - 1))) >>> spc_pkg::EXP_FB);
      yl = blend_raw(xl, mant, ip);
      yr = blend_raw(xr, mant, ip);
      w.clipped = 1'b0;
      if (yl > SAT_HI) begin yl = SAT_HI; w.clipped = 1'b1; end
      if (yl < SAT_LO) begin yl = SAT_LO; w.clipped = 1'b1; end
      if (yr > SAT_HI) begin yr = SAT_HI; w.clipped = 1'b1; end
      if (yr < SAT_LO) begin yr = SAT_LO; w.clipped = 1'b1; end
      w.left = yl[spc_pkg::SAMPLE_BITS-1:0];
      w.right = yr[spc_pkg::SAMPLE_BITS-1:0];
      w.block_end = be;
      return w;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   assign words_pending = pending_words.size();

   always @(posedge clock) begin
      stereo_word_type w;
      if (reset) begin
         regs = spc_pkg::CFG_RESET;
         env_db = -64'sd6553600;
         pending_words.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               spc_pkg::CSR_THRESHOLD: regs.threshold = csr_wdata[15:0];
               spc_pkg::CSR_SLOPE:     regs.slope = csr_wdata[15:0];
               spc_pkg::CSR_DRY:       regs.dry_level = csr_wdata[15:0];
               spc_pkg::CSR_WET:       regs.wet_level = csr_wdata[16:0];
               spc_pkg::CSR_MAKEUP:    regs.makeup = csr_wdata[15:0];
               spc_pkg::CSR_ATTACK:    regs.attack_factor = csr_wdata;
               spc_pkg::CSR_RELEASE:   regs.release_factor = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            pending_words.push_back(compress_pair(longint'(req_left_in),
               longint'(req_right_in), req_block_end_in));
         if (rsp_valid && rsp_ready) begin
            if (pending_words.size() == 0) begin
               report_mismatch("unexpected result word", 1, 0);
            end else begin
               w = pending_words.pop_front();
               if (rsp_left_out !== w.left)
                  report_mismatch("left_out", longint'(rsp_left_out),
                     longint'($signed(w.left)));
               if (rsp_right_out !== w.right)
                  report_mismatch("right_out", longint'(rsp_right_out),
                     longint'($signed(w.right)));
               if (rsp_block_end_out !== w.block_end)
                  report_mismatch("block_end_out", rsp_block_end_out, w.block_end);
               if (rsp_clipped !== w.clipped)
                  report_mismatch("clipped", rsp_clipped, w.clipped);
            end
         end
      end
   end
endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the compressor bench: clock, reset, stimulus and verdict.
// Depends on spc_pkg, stereo_parallel_compressor_core and spc_gain_checker.
module tb_top;

   localparam logic [spc_pkg::CSR_IDX_W-1:0] CSR_UNMAPPED = 3'd7;  // write is dropped
   localparam int HOLD_CYCLES = 400;

   logic clock, reset;
   logic req_valid, req_ready, req_block_end_in;
   logic signed [spc_pkg::SAMPLE_BITS-1:0] req_left_in, req_right_in;
   logic rsp_valid, rsp_ready, rsp_block_end_out, rsp_clipped;
   logic signed [spc_pkg::SAMPLE_BITS-1:0] rsp_left_out, rsp_right_out;
   logic csr_valid, csr_ready;
   logic [spc_pkg::CSR_IDX_W-1:0] csr_index;
   logic [spc_pkg::CSR_DATA_W-1:0] csr_wdata;

   int  fail_count, words_pending;
   int  words_sent, words_taken;
   bit  no_idle;     // both sides run flat out
   bit  hold_rsp;    // stimulus asks the receiver for one long hold-off
   bit  hold_done;   // receiver has served the hold-off

   stereo_parallel_compressor_core uut (.*);
   spc_gain_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off counted here
   initial begin
      rsp_ready = 0;
      hold_done = 0;
      forever begin
         @(posedge clock);
         if (hold_rsp && !hold_done) begin
            rsp_ready <= 0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1;
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= 22);
         end
      end
   end

   always @(posedge clock)
      if (reset) words_taken = 0;
      else if (rsp_valid && rsp_ready) words_taken++;

   // one stereo word; idle cycles come before valid rises
   task automatic send_word(logic signed [spc_pkg::SAMPLE_BITS-1:0] l,
                            logic signed [spc_pkg::SAMPLE_BITS-1:0] r, logic be);
      while (!no_idle && $urandom_range(99) < 22) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_left_in <= l;
      req_right_in <= r;
      req_block_end_in <= be;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   // sender pauses until every word is back, then the core goes quiet
   task automatic drain();
      req_valid <= 0;
      while (words_taken != words_sent) @(posedge clock);
      repeat (25) @(posedge clock);
   endtask

   task automatic write_reg(logic [spc_pkg::CSR_IDX_W-1:0] idx,
                            logic [spc_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // narrow registers get junk in their unused upper bits
   task automatic load_settings(int thr, int slp, int dry, int wet, int mk,
                                int att, int rel);
      write_reg(spc_pkg::CSR_THRESHOLD, {8'($urandom), 16'(thr)});
      write_reg(spc_pkg::CSR_SLOPE,     {8'($urandom), 16'(slp)});
      write_reg(spc_pkg::CSR_DRY,       {8'($urandom), 16'(dry)});
      write_reg(spc_pkg::CSR_WET,       {7'($urandom), 17'(wet)});
      write_reg(spc_pkg::CSR_MAKEUP,    {8'($urandom), 16'(mk)});
      write_reg(spc_pkg::CSR_ATTACK,    24'(att));
      write_reg(spc_pkg::CSR_RELEASE,   24'(rel));
   endtask

   function automatic logic signed [spc_pkg::SAMPLE_BITS-1:0] pick_sample();
      logic signed [spc_pkg::SAMPLE_BITS-1:0] s;
      case ($urandom_range(7))
         0, 1:    s = spc_pkg::SAMPLE_BITS'($urandom);
         2, 3, 4: begin
            // quieter material spreads the log over many octaves
            s = spc_pkg::SAMPLE_BITS'($urandom >> (8 + $urandom_range(23)));
            if ($urandom_range(1)) s = -s;
         end
         5: s = 0;
         6: s = {1'b0, {(spc_pkg::SAMPLE_BITS-1){1'b1}}};
         default: s = {1'b1, {(spc_pkg::SAMPLE_BITS-1){1'b0}}};
      endcase
      return s;
   endfunction

   task automatic random_settings(bit wild);
      if (wild)
         load_settings($urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom);
      else
         load_settings(-256 * $urandom_range(60), $urandom_range(65535),
                       $urandom_range(32768), $urandom_range(65536),
                       256 * $urandom_range(40) - 5120,
                       16777215 - $urandom_range(2000000),
                       16777215 - $urandom_range(200000));
   endtask

   initial begin
      logic signed [spc_pkg::SAMPLE_BITS-1:0] s;
      reset = 1;
      req_valid = 0;
      req_left_in = 0;
      req_right_in = 0;
      req_block_end_in = 0;
      csr_valid = 0;
      csr_index = 0;
      csr_wdata = 0;
      no_idle = 0;
      hold_rsp = 0;
      words_sent = 0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed, reset settings: silence, full scale both signs, one side only
      send_word(0, 0, 0);
      send_word({1'b0, {(spc_pkg::SAMPLE_BITS-1){1'b1}}},
                {1'b1, {(spc_pkg::SAMPLE_BITS-1){1'b0}}}, 1);
      send_word({1'b1, {(spc_pkg::SAMPLE_BITS-1){1'b0}}}, 0, 0);
      send_word(0, 1, 1);
      send_word(-1, 24'sd12345, 0);
      drain();

      // instant envelope: a repeated level equals the envelope (release path)
      load_settings(0, 65535, 0, 65536, 0, 0, 0);
      send_word(24'sd40000, -24'sd40000, 0);
      send_word(-24'sd40000, 24'sd40000, 0);
      send_word(0, 0, 1);
      drain();

      // gains above nominal, huge makeup: wet clamp and saturation
      load_settings(32767, 0, 65535, 131071, 32767, 16777215, 16777215);
      write_reg(CSR_UNMAPPED, spc_pkg::CSR_DATA_W'($urandom));
      send_word(24'sd1, -24'sd1, 0);
      send_word(24'sd5000000, -24'sd5000000, 1);
      send_word({1'b1, {(spc_pkg::SAMPLE_BITS-1){1'b0}}}, 24'sd77, 0);
      drain();

      // lowest threshold, deepest cut
      load_settings(-32768, 65535, 32768, 0, -32768, 1, 16777214);
      send_word(24'sd8000000, 24'sd3, 1);
      send_word(-24'sd2, 0, 0);
      send_word(0, 0, 0);
      drain();

      // random phases; third one flat out, fourth one with a long hold-off
      for (int ph = 0; ph < 9; ph++) begin
         if (ph > 0) random_settings(ph == 5 || ph == 8);
         no_idle = (ph == 2);
         for (int n = 0; n < 120; n++) begin
            if (ph == 3 && n == 10) hold_rsp = 1;
            s = pick_sample();
            send_word(s, $urandom_range(3) == 0 ? s : pick_sample(),
                      $urandom_range(15) == 0);
         end
         drain();
      end

      if (fail_count == 0 && words_pending == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
